@@ src/swm_pkg.sv @@
package swm_pkg;

  localparam int CFG_WIDTH = 7;
  localparam logic [CFG_WIDTH-1:0] CFG_RESET = 7'd1;

  typedef enum logic [5:0] {
    ST_IDLE       = 6'b000001,
    ST_EXP_ISSUE  = 6'b000010,
    ST_EXP_CHECK  = 6'b000100,
    ST_DROP_ISSUE = 6'b001000,
    ST_DROP_CHECK = 6'b010000,
    ST_PUSH       = 6'b100000
  } state_t;

endpackage

@@ src/sliding_window_max.sv @@
// Channel  | Dir | Handshake                 | Payload
// ---------+-----+---------------------------+------------------------------------------
// in_      | in  | in_tvalid / in_tready     | tdata: sample; tuser: start; tlast: end
// out_     | out | out_tvalid / out_tready   | tdata: window_max; tlast: last_result
// cfg_     | in  | cfg_valid / cfg_ready     | cfg_data: window_size
//
// A sample steps through idle, an expire scan from the head and a drop scan from the tail,
// where each queue entry is first issued as a read and then checked, and a push; a result
// is handed out from idle. The single-read-port queue RAM is why each entry needs both.
// Reset (rst_n, synchronous) empties the queue and sets window_size to 1; the RAM
// itself is not cleared. A stalled result waits in the output register while the
// next sample is taken; the block holds off only when a second result is ready.
module sliding_window_max
  import swm_pkg::*;
#(
  parameter int MAX_WINDOW   = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] in_tdata,  // [SW-1:0] sample, zero pad
  input  logic                             in_tuser,  // [0] start_of_sequence
  input  logic                             in_tlast,  // end_of_sequence
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] out_tdata, // [SW-1:0] window_max, zero pad
  output logic                             out_tlast, // last_result
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [CFG_WIDTH-1:0]             cfg_data
);

  localparam int DW      = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int AW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WW      = $clog2(MAX_WINDOW + 1);
  localparam int POS_MOD = 2 * MAX_WINDOW;
  localparam int PW      = $clog2(POS_MOD);
  localparam int EW      = SAMPLE_WIDTH + PW;

  localparam logic [AW-1:0] IDX_LAST = AW'(MAX_WINDOW - 1);
  localparam logic [PW-1:0] POS_LAST = PW'(POS_MOD - 1);
  localparam logic [WW-1:0] WIN_MAX  = WW'(MAX_WINDOW);

  // queue RAM: {position, value}
  logic [EW-1:0] mem [MAX_WINDOW];
  logic [EW-1:0] rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          wr_en;

  state_t                   state_r, state_nxt;
  logic [CFG_WIDTH-1:0]     win_cfg_r, win_cfg_nxt;
  logic [AW-1:0]            head_r, head_nxt;
  logic [AW-1:0]            tail_r, tail_nxt;
  logic [WW-1:0]            count_r, count_nxt;
  logic [PW-1:0]            pos_r, pos_nxt;
  logic [WW-1:0]            fill_r, fill_nxt;
  logic [WW-1:0]            win_r, win_nxt;
  logic [SAMPLE_WIDTH-1:0]  samp_r, samp_nxt;
  logic                     eos_r, eos_nxt;
  logic [SAMPLE_WIDTH-1:0]  head_val_r, head_val_nxt;
  logic                     res_pend_r, res_pend_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [SAMPLE_WIDTH-1:0]  out_val_r, out_val_nxt;
  logic                     out_last_r, out_last_nxt;

  logic [SAMPLE_WIDTH-1:0]  rd_val;
  logic [PW-1:0]            rd_pos;
  logic [PW:0]              age;
  logic [WW-1:0]            win_eff;
  logic [AW-1:0]            tail_prev;
  logic [WW-1:0]            fill_inc;
  logic                     out_free;

  assign rd_val    = rd_data_r[SAMPLE_WIDTH-1:0];
  assign rd_pos    = rd_data_r[EW-1:SAMPLE_WIDTH];
  assign tail_prev = (tail_r == '0) ? IDX_LAST : tail_r - AW'(1);
  assign out_free  = !out_valid_r || out_tready;

  // age of the head entry, modulo 2*MAX_WINDOW
  always_comb begin
    if (pos_r >= rd_pos) begin
      age = {1'b0, pos_r} - {1'b0, rd_pos};
    end else begin
      age = {1'b0, pos_r} + (PW+1)'(POS_MOD) - {1'b0, rd_pos};
    end
  end

  // clamp window size into 1..MAX_WINDOW
  always_comb begin
    if (win_cfg_r == '0) begin
      win_eff = WW'(1);
    end else if (32'(win_cfg_r) > 32'(MAX_WINDOW)) begin
      win_eff = WIN_MAX;
    end else begin
      win_eff = WW'(win_cfg_r);
    end
  end

  assign fill_inc = (fill_r < WIN_MAX) ? fill_r + WW'(1) : fill_r;

  always_comb begin
    state_nxt     = state_r;
    win_cfg_nxt   = win_cfg_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    fill_nxt      = fill_r;
    win_nxt       = win_r;
    samp_nxt      = samp_r;
    eos_nxt       = eos_r;
    head_val_nxt  = head_val_r;
    res_pend_nxt  = res_pend_r;
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;
    out_last_nxt  = out_last_r;
    rd_addr       = head_r;
    wr_en         = 1'b0;

    if (cfg_valid) begin
      win_cfg_nxt = cfg_data;
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (res_pend_r) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_val_nxt   = head_val_r;
            out_last_nxt  = eos_r;
            res_pend_nxt  = 1'b0;
          end
        end else if (in_tvalid) begin
          samp_nxt = in_tdata[SAMPLE_WIDTH-1:0];
          eos_nxt  = in_tlast;
          win_nxt  = win_eff;
          if (in_tuser) begin
            head_nxt  = '0;
            tail_nxt  = '0;
            count_nxt = '0;
            pos_nxt   = '0;
            fill_nxt  = '0;
          end
          state_nxt = ST_EXP_ISSUE;
        end
      end
      ST_EXP_ISSUE: begin
        rd_addr = head_r;
        if (count_r == '0) begin
          state_nxt = ST_DROP_ISSUE;
        end else begin
          state_nxt = ST_EXP_CHECK;
        end
      end
      ST_EXP_CHECK: begin
        if (age >= (PW+1)'(win_r)) begin
          head_nxt  = (head_r == IDX_LAST) ? '0 : head_r + AW'(1);
          count_nxt = count_r - WW'(1);
          state_nxt = ST_EXP_ISSUE;
        end else begin
          head_val_nxt = rd_val;
          state_nxt    = ST_DROP_ISSUE;
        end
      end
      ST_DROP_ISSUE: begin
        rd_addr = tail_prev;
        if (count_r == '0) begin
          state_nxt = ST_PUSH;
        end else begin
          state_nxt = ST_DROP_CHECK;
        end
      end
      ST_DROP_CHECK: begin
        if ($signed(rd_val) <= $signed(samp_r)) begin
          tail_nxt  = tail_prev;
          count_nxt = count_r - WW'(1);
          state_nxt = ST_DROP_ISSUE;
        end else begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        wr_en     = 1'b1;
        tail_nxt  = (tail_r == IDX_LAST) ? '0 : tail_r + AW'(1);
        count_nxt = count_r + WW'(1);
        pos_nxt   = (pos_r == POS_LAST) ? '0 : pos_r + PW'(1);
        fill_nxt  = fill_inc;
        // queue emptied: the new sample becomes the head
        if (count_r == '0) begin
          head_val_nxt = samp_r;
        end
        res_pend_nxt = (fill_inc >= win_r);
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_r] <= {pos_r, samp_r};
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      win_cfg_r   <= CFG_RESET;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      pos_r       <= '0;
      fill_r      <= '0;
      res_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      win_cfg_r   <= win_cfg_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      fill_r      <= fill_nxt;
      res_pend_r  <= res_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r      <= win_nxt;
    samp_r     <= samp_nxt;
    eos_r      <= eos_nxt;
    head_val_r <= head_val_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE) && !res_pend_r;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = DW'(out_val_r);
  assign out_tlast  = out_last_r;

endmodule

@@ tb/sliding_window_max_check.sv @@
module sliding_window_max_check
  import swm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [15:0]          in_tdata,  // [15:0] sample
  input  logic                 in_tuser,  // [0] start_of_sequence
  input  logic                 in_tlast,  // end_of_sequence
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [15:0]          out_tdata, // [15:0] window_max
  input  logic                 out_tlast, // last_result
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_WIDTH-1:0] cfg_data,
  output int                   fail_count,
  output int                   pending
);

  localparam int MAX_WIN = 64;
  localparam int REPORT_LIMIT = 10;

  // monotonic max queue: values strictly decreasing from head to tail
  logic signed [15:0] mono_vals[$];
  logic [6:0]         mono_pos[$];
  logic [6:0]         window_size;
  logic [6:0]         next_pos;
  int                 fill;

  logic signed [15:0] due_max[$];
  logic               due_last[$];
  int                 errors = 0;

  function automatic int clamp_window(input logic [6:0] code);
    if (code == 7'd0) return 1;
    if (code > MAX_WIN) return MAX_WIN;
    return int'(code);
  endfunction

  task automatic clear_window();
    mono_vals.delete();
    mono_pos.delete();
    next_pos = '0;
    fill = 0;
  endtask

  task automatic slide_in(input logic signed [15:0] s, input logic sos, input logic eos);
    int         w;
    logic [6:0] age;
    logic       expired;
    w = clamp_window(window_size);
    if (sos) clear_window();
    expired = 1'b1;
    while (expired && mono_vals.size() > 0) begin
      age = next_pos - mono_pos[0];  // wraps mod 128
      if (age < w) begin
        expired = 1'b0;
      end else begin
        mono_vals.delete(0);
        mono_pos.delete(0);
      end
    end
    while (mono_vals.size() > 0 && mono_vals[mono_vals.size()-1] <= s) begin
      mono_vals.delete(mono_vals.size()-1);
      mono_pos.delete(mono_pos.size()-1);
    end
    mono_vals = {mono_vals, s};
    mono_pos = {mono_pos, next_pos};
    next_pos = next_pos + 7'd1;
    if (fill < MAX_WIN) fill++;
    if (fill >= w) begin
      due_max = {due_max, mono_vals[0]};
      due_last = {due_last, eos};
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_window();
      window_size = CFG_RESET;
      due_max.delete();
      due_last.delete();
    end else begin
      if (cfg_valid && cfg_ready) window_size = cfg_data;
      if (in_tvalid && in_tready) slide_in($signed(in_tdata), in_tuser, in_tlast);
      if (out_tvalid && out_tready) begin
        if (due_max.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("unexpected result: window_max=%0d last=%0b",
                     $signed(out_tdata), out_tlast);
        end else begin
          if (out_tdata !== due_max[0] || out_tlast !== due_last[0]) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display("result mismatch: window_max exp %0d got %0d, last exp %0b got %0b",
                       due_max[0], $signed(out_tdata), due_last[0], out_tlast);
          end
          due_max.delete(0);
          due_last.delete(0);
        end
      end
    end
    fail_count <= errors;
    pending <= due_max.size();
  end

endmodule

@@ tb/sliding_window_max_tb.sv @@
module sliding_window_max_tb
  import swm_pkg::*;
();

  localparam int TOTAL_ITEMS   = 1850;
  localparam int SETTLE_CYCLES = 200;   // covers a full-depth queue scan
  localparam int LONG_HOLD     = 400;
  localparam int STALL_LIMIT   = 3000;

  typedef enum int {
    SHAPE_RANDOM,
    SHAPE_NARROW,
    SHAPE_FALL,
    SHAPE_RISE,
    SHAPE_EXTREME
  } shape_t;

  typedef enum int {
    RUN_FULL,
    RUN_SHORT,
    RUN_NOISE,
    RUN_CONT
  } run_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [15:0]          in_tdata = '0;  // [15:0] sample
  logic                 in_tuser = 1'b0; // [0] start_of_sequence
  logic                 in_tlast = 1'b0; // end_of_sequence
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [15:0]          out_tdata;      // [15:0] window_max
  logic                 out_tlast;      // last_result
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_WIDTH-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int sent = 0;
  int gap_max = 17;
  int idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sliding_window_max dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  sliding_window_max_check u_window_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // watchdog: cycles without any transfer on any channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_sample(input logic [15:0] s, input logic sos, input logic eos);
    int gap;
    gap = $urandom_range(0, gap_max);
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tuser  <= sos;
    in_tlast  <= eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  // pending is updated by NBA, so the extra edge sees the last transfer counted
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [6:0] code);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= code;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int clamp_window(input logic [6:0] code);
    if (code == 7'd0) return 1;
    if (code > 7'd64) return 64;
    return int'(code);
  endfunction

  function automatic logic [6:0] draw_window();
    int r;
    r = $urandom_range(0, 15);
    if (r < 8) return 7'($urandom_range(1, 8));
    if (r < 11) return 7'($urandom_range(9, 63));
    if (r == 11) return 7'd64;
    if (r == 12) return 7'd0;
    if (r == 13) return 7'($urandom_range(65, 127));
    if (r == 14) return 7'd127;
    return 7'd2;
  endfunction

  function automatic logic [15:0] draw_sample(input shape_t shape, inout int level);
    int v;
    case (shape)
      SHAPE_NARROW: begin
        v = $urandom_range(0, 8);
        return 16'(v - 4);
      end
      SHAPE_FALL: begin
        level = level - int'($urandom_range(0, 400));
        if (level < -32768) level = 32767;
        return 16'(level);
      end
      SHAPE_RISE: begin
        level = level + int'($urandom_range(0, 400));
        if (level > 32767) level = -32768;
        return 16'(level);
      end
      SHAPE_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       return 16'h8000;
          1:       return 16'h7fff;
          2:       return 16'h0000;
          default: return 16'hffff;
        endcase
      end
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_run(input run_t kind, input int w);
    int     len;
    int     level;
    shape_t shape;
    logic   sos;
    logic   eos;
    shape = shape_t'($urandom_range(0, 4));
    level = int'($urandom_range(0, 65535)) - 32768;
    case (kind)
      RUN_FULL:  len = w + $urandom_range(0, w + 8);
      RUN_SHORT: len = (w > 1) ? $urandom_range(1, w - 1) : 1;
      RUN_NOISE: len = $urandom_range(1, 24);
      default:   len = $urandom_range(1, w + 8);
    endcase
    for (int i = 0; i < len; i++) begin
      if (kind == RUN_NOISE) begin
        sos = ($urandom_range(0, 3) == 0);
        eos = ($urandom_range(0, 3) == 0);
      end else begin
        sos = (i == 0) && (kind != RUN_CONT);
        eos = (i == len - 1);
      end
      send_sample(draw_sample(shape, level), sos, eos);
    end
  endtask

  initial begin : stimulus
    logic [6:0] code;
    int         w;
    int         runs;
    int         r;
    run_t       kind;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset window of 1, stream begins without a start flag
    send_sample(16'h8000, 1'b0, 1'b0);
    send_sample(16'h7fff, 1'b0, 1'b0);
    send_sample(16'h0000, 1'b0, 1'b0);
    send_sample(16'hffff, 1'b0, 1'b1);
    // zero reads as 1; equal samples
    write_window(7'd0);
    send_sample(-16'sd5, 1'b1, 1'b0);
    send_sample(16'sd7, 1'b0, 1'b0);
    send_sample(16'sd7, 1'b0, 1'b1);
    // oversize clamps to 64; short sequence gives nothing
    write_window(7'd127);
    send_sample(16'sd1, 1'b1, 1'b0);
    send_sample(16'sd2, 1'b0, 1'b0);
    send_sample(16'sd3, 1'b0, 1'b1);
    // falling run expires the head
    write_window(7'd3);
    send_sample(16'sd10, 1'b1, 1'b0);
    send_sample(16'sd9, 1'b0, 1'b0);
    send_sample(16'sd8, 1'b0, 1'b0);
    send_sample(16'sd7, 1'b0, 1'b0);
    send_sample(16'sd8, 1'b0, 1'b0);
    send_sample(16'sd8, 1'b0, 1'b0);
    send_sample(16'sd20, 1'b0, 1'b1);
    // window shrinks while the sequence continues
    write_window(7'd2);
    send_sample(16'sd100, 1'b0, 1'b0);
    send_sample(-16'sd100, 1'b0, 1'b1);

    while (sent < TOTAL_ITEMS) begin
      code = draw_window();
      w = clamp_window(code);
      write_window(code);
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
      runs = (w > 16) ? 2 : $urandom_range(2, 6);
      repeat (runs) begin
        r = $urandom_range(0, 9);
        if (r < 6)       kind = RUN_FULL;
        else if (r == 6) kind = RUN_SHORT;
        else if (r == 7) kind = RUN_NOISE;
        else             kind = RUN_CONT;
        send_run(kind, w);
      end
    end

    wait_drained();
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // result side: random stalls, stretches with none, two long hold-offs
  initial begin : result_sink
    int hold;
    int taken;
    taken = 0;
    @(posedge clk);
    forever begin
      if (taken == 100 || taken == 1000)
        hold = LONG_HOLD;
      else if ((taken % 160) < 40)
        hold = 0;
      else
        hold = $urandom_range(0, 17);
      repeat (hold) begin
        out_tready <= 1'b0;
        @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      taken++;
    end
  end

endmodule
